[rtl/tts_pkg.sv]
// Shared types and constants for the timer table scheduler.
// No dependencies; every other file except tts_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int MAX_FIRES     = 16;
   localparam int FIRE_W        = $clog2(MAX_FIRES + 1);
   localparam int DL_W          = 41;
   localparam logic [31:0] WAIT_MAX = 32'h7FFF_FFFF;

   // action / kind codes
   localparam logic [2:0] ACT_ADD    = 3'd0;
   localparam logic [2:0] ACT_CANCEL = 3'd1;
   localparam logic [2:0] ACT_TICK   = 3'd2;
   localparam logic [2:0] ACT_QUERY  = 3'd3;
   localparam logic [2:0] ACT_CLEAR  = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [39:0] now_ms;
      logic [31:0] delay_ms;
      logic        repeating;
      logic [31:0] timer_id;
   } tts_req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        result_id;
      logic               ok;
      logic signed [31:0] wait_ms;
      logic               last;
   } tts_rsp_type;

   typedef struct packed {
      logic [DL_W-1:0] deadline;
      logic [31:0]     period;
      logic            repeat_en;
      logic [31:0]     ident;
   } tts_slot_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } tts_cmd_type;

   typedef struct packed {
      logic scan_done;
   } tts_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } tts_state_type;

endpackage

`default_nettype wire

[rtl/tts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/tts_ctrl.sv]
// Sequencer for the timer table: load, slot scan, final result.
// Depends on tts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tts_ctrl import tts_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  tts_status_type      status,
   output tts_cmd_type         cmd,
   output logic                busy
);

   tts_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/tts_dp.sv]
// Datapath: request register, slot valid bits, slot RAM, scan pipeline,
// per-action evaluation and result register. Depends on tts_pkg, tts_ram.
`timescale 1ns / 1ps
`default_nettype none

module tts_dp import tts_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  tts_cmd_type         cmd,
   output tts_status_type      status,
   input  tts_req_type         req_data,
   output logic                rsp_strobe,
   output tts_rsp_type         rsp_data
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int SW = $bits(tts_slot_type);

   tts_req_type       req_ff, req_in;
   logic [CW-1:0]     rd_cnt_ff, rd_cnt_in;
   logic              eval_vld_ff, eval_vld_in;
   logic [IW-1:0]     eval_idx_ff, eval_idx_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic              hit_ff, hit_in;
   logic              pend_ff, pend_in;
   logic [31:0]       pend_id_ff, pend_id_in;
   logic [FIRE_W-1:0] fire_cnt_ff, fire_cnt_in;
   logic [DL_W-1:0]   best_ff, best_in;
   logic [31:0]       add_id_ff, add_id_in;
   logic [31:0]       next_ident_ff, next_ident_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   tts_rsp_type       rsp_ff, rsp_in;

   logic              issue, eval, cur_valid, due;
   logic [31:0]       addend;
   logic [DL_W-1:0]   sum;
   logic [DL_W:0]     diff;
   logic [SW-1:0]     ram_rd_data;
   tts_slot_type      rd_entry, wr_entry;
   logic              wr_en;

   tts_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (eval_idx_ff),
      .wr_data (wr_entry),
      .rd_addr (rd_cnt_ff[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff     <= '0;
         eval_vld_ff   <= 1'b0;
         valid_ff      <= '0;
         hit_ff        <= 1'b0;
         pend_ff       <= 1'b0;
         fire_cnt_ff   <= '0;
         next_ident_ff <= 32'd1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rd_cnt_ff     <= rd_cnt_in;
         eval_vld_ff   <= eval_vld_in;
         valid_ff      <= valid_in;
         hit_ff        <= hit_in;
         pend_ff       <= pend_in;
         fire_cnt_ff   <= fire_cnt_in;
         next_ident_ff <= next_ident_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      eval_idx_ff <= eval_idx_in;
      pend_id_ff  <= pend_id_in;
      best_ff     <= best_in;
      add_id_ff   <= add_id_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      rd_entry  = tts_slot_type'(ram_rd_data);
      issue     = cmd.scan && (rd_cnt_ff != CW'(SLOTS));
      eval      = cmd.scan && eval_vld_ff;
      cur_valid = valid_ff[eval_idx_ff];
      due       = cur_valid && ({1'b0, req_ff.now_ms} >= rd_entry.deadline);
      addend    = (req_ff.action == ACT_ADD) ? req_ff.delay_ms : rd_entry.period;
      sum       = {1'b0, req_ff.now_ms} + {9'd0, addend};
      diff      = {1'b0, best_ff} - {2'b00, req_ff.now_ms};

      req_in        = req_ff;
      rd_cnt_in     = rd_cnt_ff;
      eval_vld_in   = 1'b0;
      eval_idx_in   = eval_idx_ff;
      valid_in      = valid_ff;
      hit_in        = hit_ff;
      pend_in       = pend_ff;
      pend_id_in    = pend_id_ff;
      fire_cnt_in   = fire_cnt_ff;
      best_in       = best_ff;
      add_id_in     = add_id_ff;
      next_ident_in = next_ident_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_entry      = rd_entry;

      if (cmd.load) begin
         req_in      = req_data;
         rd_cnt_in   = '0;
         hit_in      = 1'b0;
         pend_in     = 1'b0;
         fire_cnt_in = '0;
      end

      if (issue) begin
         eval_vld_in = 1'b1;
         eval_idx_in = rd_cnt_ff[IW-1:0];
         rd_cnt_in   = rd_cnt_ff + CW'(1);
      end

      if (eval) begin
         unique case (req_ff.action)
            ACT_ADD: begin
               if (!cur_valid && !hit_ff) begin
                  wr_en              = 1'b1;
                  wr_entry.deadline  = sum;
                  wr_entry.period    = req_ff.delay_ms;
                  wr_entry.repeat_en = req_ff.repeating;
                  wr_entry.ident     = next_ident_ff;
                  valid_in[eval_idx_ff] = 1'b1;
                  hit_in    = 1'b1;
                  add_id_in = next_ident_ff;
                  next_ident_in = (next_ident_ff == 32'hFFFF_FFFF) ? 32'd1
                                                                   : next_ident_ff + 32'd1;
               end
            end
            ACT_CANCEL: begin
               if (cur_valid && (req_ff.timer_id != 32'd0)
                   && (rd_entry.ident == req_ff.timer_id)) begin
                  valid_in[eval_idx_ff] = 1'b0;
                  hit_in = 1'b1;
               end
            end
            ACT_TICK: begin
               if (due && (fire_cnt_ff < FIRE_W'(MAX_FIRES))) begin
                  // previous fire goes out now; this one waits to learn if it is last
                  if (pend_ff) begin
                     rsp_strobe_in    = 1'b1;
                     rsp_in.kind      = ACT_TICK;
                     rsp_in.result_id = pend_id_ff;
                     rsp_in.ok        = 1'b1;
                     rsp_in.wait_ms   = '0;
                     rsp_in.last      = 1'b0;
                  end
                  pend_in     = 1'b1;
                  pend_id_in  = rd_entry.ident;
                  fire_cnt_in = fire_cnt_ff + FIRE_W'(1);
                  if (rd_entry.repeat_en) begin
                     wr_en             = 1'b1;
                     wr_entry.deadline = sum;
                  end else begin
                     valid_in[eval_idx_ff] = 1'b0;
                  end
               end
            end
            ACT_QUERY: begin
               if (cur_valid && (!hit_ff || (rd_entry.deadline < best_ff))) begin
                  best_in = rd_entry.deadline;
                  hit_in  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.finish) begin
         rsp_strobe_in    = 1'b1;
         rsp_in.kind      = req_ff.action;
         rsp_in.result_id = '0;
         rsp_in.ok        = 1'b0;
         rsp_in.wait_ms   = '0;
         rsp_in.last      = 1'b1;
         unique case (req_ff.action)
            ACT_ADD: begin
               rsp_in.ok        = hit_ff;
               rsp_in.result_id = hit_ff ? add_id_ff : 32'd0;
            end
            ACT_CANCEL: begin
               rsp_in.ok = hit_ff;
            end
            ACT_TICK: begin
               rsp_in.ok        = pend_ff;
               rsp_in.result_id = pend_ff ? pend_id_ff : 32'd0;
            end
            ACT_QUERY: begin
               if (!hit_ff) begin
                  rsp_in.wait_ms = '1;
               end else if (diff[DL_W] || (diff == '0)) begin
                  rsp_in.wait_ms = '0;
               end else if (diff[DL_W-1:31] != '0) begin
                  rsp_in.wait_ms = WAIT_MAX;
               end else begin
                  rsp_in.wait_ms = diff[31:0];
               end
            end
            ACT_CLEAR: begin
               valid_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign status.scan_done = (rd_cnt_ff == CW'(SLOTS)) && !eval_vld_ff;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_data         = rsp_ff;

endmodule

`default_nettype wire

[rtl/timer_table_scheduler_core.sv]
// Top level of the timer table scheduler: controller plus datapath.
// Depends on tts_pkg, tts_ctrl, tts_dp (and tts_ram below it).
`timescale 1ns / 1ps
`default_nettype none

// Timer slot table with add, cancel, tick, query and clear commands.
// A command transfer happens on a rising edge with start high and busy
// low. Until busy falls again, the datapath walks the slot RAM one entry
// per cycle through its single read port, whose read data is registered;
// then the scan sees that it has ended and the closing result is formed.
// Results are strobed on rsp_strobe for exactly one cycle each and cannot
// be held off. A tick produces its fires in slot order while the scan runs;
// the final result of every command (last = 1) is strobed in the cycle in
// which busy drops, so a new command can be issued in that same cycle.
// A tick fires at most 16 slots; further due slots wait for a later tick.
module timer_table_scheduler_core import tts_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  start,
   output logic       busy,
   input  tts_req_type req_data,
   output logic       rsp_strobe,
   output tts_rsp_type rsp_data
);

   tts_cmd_type    cmd;
   tts_status_type status;

   // sequencing only; all table state and arithmetic live in the datapath
   tts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   tts_dp #(.SLOTS(SLOTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // closing result lands exactly when the block frees up
   a_final_on_release: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && rsp_data.last))
      else $error("final result not strobed when busy fell");

   // only the final result may appear while idle
   a_partial_while_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> busy)
      else $error("non-final result outside a command");

   // only tick commands produce more than one result
   a_single_result_kinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.kind != ACT_TICK)) |-> rsp_data.last)
      else $error("non-tick result without last");

   // a command transfer always starts a scan
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after command transfer");

endmodule

`default_nettype wire

[sim/tb_timer_table_scheduler_core.sv]
// Testbench for timer_table_scheduler_core: queued command driver, result monitor and
// a cycle-free model of the slot table that predicts every result transfer.
// Depends on rtl/tts_pkg.sv and the scheduler RTL; reads no files.
`timescale 1ns / 1ps

module tb_timer_table_scheduler_core;
   import tts_pkg::*;

   localparam int SLOTS       = SLOTS_DEFAULT;
   localparam int STALL_LIMIT = 2000;   // cycles without any transfer
   localparam int RAND_CMDS   = 280;

   // action codes the block does not know; they must echo and change nothing
   localparam logic [2:0] ACT_SPARE_LO = ACT_CLEAR + 3'd1;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   typedef struct {
      tts_req_type req;
      bit          drain;   // hold this command until all results are back
   } timer_cmd_type;

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   tts_req_type req_data = '0;
   logic        busy;
   logic        rsp_strobe;
   tts_rsp_type rsp_data;

   timer_cmd_type cmd_q[$];
   tts_rsp_type   sched_rsp_q[$];

   // shadow slot table
   bit              slot_live[SLOTS];
   logic [DL_W-1:0] slot_due_at[SLOTS];
   logic [31:0]     slot_every[SLOTS];
   logic            slot_periodic[SLOTS];
   logic [31:0]     slot_id[SLOTS];
   logic [31:0]     next_id = 32'd1;

   int stim_total;
   int n_cmds_taken  = 0;   // written by the driver only
   int n_cmds_closed = 0;   // written by the monitor only (nonblocking)
   int n_rsp_seen    = 0;
   int n_mismatch    = 0;
   int n_fires       = 0;
   int n_full_adds   = 0;
   int gap_left      = 0;
   int sender_idle_pct;
   int idle_cycles   = 0;
   tts_rsp_type want;
   bit          rsp_bad;

   always #5 clock = ~clock;

   timer_table_scheduler_core #(.SLOTS(SLOTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   function automatic tts_rsp_type rsp_of(logic [2:0] kind, logic [31:0] id, logic ok,
                                          logic [31:0] wait_v, logic last);
      tts_rsp_type r;
      r.kind      = kind;
      r.result_id = id;
      r.ok        = ok;
      r.wait_ms   = wait_v;
      r.last      = last;
      return r;
   endfunction

   // append one predicted result transfer
   function automatic void expect_rsp(tts_rsp_type r);
      sched_rsp_q.insert(sched_rsp_q.size(), r);
   endfunction

   // Apply one command to the shadow table and queue the results it causes.
   function automatic void run_timer_table(tts_req_type cmd);
      logic [DL_W-1:0] now41;
      logic [DL_W-1:0] best;
      logic [DL_W-1:0] gap;
      logic [31:0]     wait_v;
      logic [31:0]     id;
      bit              any;
      bit              found;
      tts_rsp_type     fire_q[$];
      now41 = {1'b0, cmd.now_ms};
      case (cmd.action)
         ACT_ADD: begin
            found = 1'b0;
            id    = '0;
            // lowest free slot wins
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && !slot_live[i]) begin
                  found            = 1'b1;
                  id               = next_id;
                  slot_live[i]     = 1'b1;
                  slot_due_at[i]   = now41 + {{(DL_W-32){1'b0}}, cmd.delay_ms};
                  slot_every[i]    = cmd.delay_ms;
                  slot_periodic[i] = cmd.repeating;
                  slot_id[i]       = next_id;
                  next_id = (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;
               end
            end
            if (!found) n_full_adds++;
            expect_rsp(rsp_of(ACT_ADD, id, found, '0, 1'b1));
         end
         ACT_CANCEL: begin
            found = 1'b0;
            // every matching slot goes, identifier zero never matches
            if (cmd.timer_id != '0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_live[i] && slot_id[i] == cmd.timer_id) begin
                     slot_live[i] = 1'b0;
                     found        = 1'b1;
                  end
               end
            end
            expect_rsp(rsp_of(ACT_CANCEL, '0, found, '0, 1'b1));
         end
         ACT_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (fire_q.size() < MAX_FIRES && slot_live[i] && now41 >= slot_due_at[i]) begin
                  fire_q.insert(fire_q.size(), rsp_of(ACT_TICK, slot_id[i], 1'b1, '0, 1'b0));
                  if (slot_periodic[i]) begin
                     slot_due_at[i] = now41 + {{(DL_W-32){1'b0}}, slot_every[i]};
                  end else begin
                     slot_live[i] = 1'b0;
                  end
               end
            end
            if (fire_q.size() == 0) begin
               expect_rsp(rsp_of(ACT_TICK, '0, 1'b0, '0, 1'b1));
            end else begin
               n_fires += fire_q.size();
               fire_q[fire_q.size()-1].last = 1'b1;
               foreach (fire_q[k]) expect_rsp(fire_q[k]);
            end
         end
         ACT_QUERY: begin
            any  = 1'b0;
            best = '0;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_live[i] && (!any || slot_due_at[i] < best)) begin
                  best = slot_due_at[i];
                  any  = 1'b1;
               end
            end
            gap = best - now41;
            if (!any)                 wait_v = 32'hFFFF_FFFF;   // empty table: -1
            else if (best <= now41)   wait_v = '0;              // already overdue
            else if (gap > {{(DL_W-32){1'b0}}, WAIT_MAX}) wait_v = WAIT_MAX;
            else                      wait_v = gap[31:0];
            expect_rsp(rsp_of(ACT_QUERY, '0, 1'b0, wait_v, 1'b1));
         end
         ACT_CLEAR: begin
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            expect_rsp(rsp_of(ACT_CLEAR, '0, 1'b0, '0, 1'b1));
         end
         default: begin
            expect_rsp(rsp_of(cmd.action, '0, 1'b0, '0, 1'b1));
         end
      endcase
   endfunction

   function automatic tts_req_type mk_cmd(logic [2:0] act, logic [39:0] now, logic [31:0] dly,
                                          logic rep, logic [31:0] tid);
      tts_req_type c;
      c.action    = act;
      c.now_ms    = now;
      c.delay_ms  = dly;
      c.repeating = rep;
      c.timer_id  = tid;
      return c;
   endfunction

   function automatic tts_req_type noise_cmd();
      return mk_cmd(3'($urandom()), {8'($urandom()), $urandom()}, $urandom(),
                    1'($urandom()), $urandom());
   endfunction

   function automatic void queue_cmd(tts_req_type c);
      timer_cmd_type t;
      t.req   = c;
      t.drain = ($urandom_range(99) < 3);
      cmd_q.insert(cmd_q.size(), t);
   endfunction

   // ------------------------------------------------------------------
   // Driver: a command transfer happens on an edge with start high and
   // busy low. The command is modeled right there. After a transfer the
   // sender may sit out a random gap, long enough to land before, on or
   // after the edge where busy drops. Commands marked drain wait until
   // the last result of every earlier command has been seen.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         sender_idle_pct = (n_cmds_taken < stim_total / 3)     ? 24 :
                           (n_cmds_taken < 2 * stim_total / 3) ? 87 : 0;
         if (start && !busy) begin
            run_timer_table(req_data);
            n_cmds_taken++;
            if ($urandom_range(99) < sender_idle_pct) gap_left = $urandom_range(24, 1);
         end
         // line is free unless a command is still held against busy
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (cmd_q.size() != 0 &&
                         (!cmd_q[0].drain || n_cmds_closed == n_cmds_taken)) begin
               start    <= 1'b1;
               req_data <= cmd_q[0].req;
               void'(cmd_q.pop_front());
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every strobed result is a transfer; compare it against the
   // oldest prediction field by field.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         n_rsp_seen++;
         if (rsp_data.last) n_cmds_closed <= n_cmds_closed + 1;
         if (sched_rsp_q.size() == 0) begin
            $error("result with nothing outstanding: kind %0d id %0d",
                   rsp_data.kind, rsp_data.result_id);
            n_mismatch++;
         end else begin
            want    = sched_rsp_q.pop_front();
            rsp_bad = 1'b0;
            if (rsp_data.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_data.kind);
               rsp_bad = 1'b1;
            end
            if (rsp_data.result_id !== want.result_id) begin
               $error("result_id: expected %0d, got %0d", want.result_id, rsp_data.result_id);
               rsp_bad = 1'b1;
            end
            if (rsp_data.ok !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, rsp_data.ok);
               rsp_bad = 1'b1;
            end
            if (rsp_data.wait_ms !== want.wait_ms) begin
               $error("wait_ms: expected %0d, got %0d", want.wait_ms, rsp_data.wait_ms);
               rsp_bad = 1'b1;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_data.last);
               rsp_bad = 1'b1;
            end
            if (rsp_bad) n_mismatch++;
         end
      end
   end

   // Watchdog: any transfer in either direction resets the count.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
      else                                idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      tts_req_type c;
      logic [39:0] now_base;
      logic [31:0] id_hint;
      int          n_rand;
      int          pick;
      int          sel;
      int          burst;

      // directed: empty table, deadline edges, period zero, far and
      // overdue deadlines, cancel misses, spare actions, clear
      queue_cmd(mk_cmd(ACT_QUERY,  40'd0, '0, 1'b0, '0));             // empty -> -1
      queue_cmd(mk_cmd(ACT_TICK,   40'd0, '0, 1'b0, '0));             // nothing due
      queue_cmd(mk_cmd(ACT_CANCEL, 40'd0, '0, 1'b0, 32'd0));          // id zero
      queue_cmd(mk_cmd(ACT_ADD,    40'd0, 32'd0, 1'b0, '0));          // id 1
      queue_cmd(mk_cmd(ACT_ADD,    40'd0, 32'hFFFF_FFFF, 1'b1, '0));  // id 2
      queue_cmd(mk_cmd(ACT_QUERY,  40'd0, '0, 1'b0, '0));             // deadline == now
      queue_cmd(mk_cmd(ACT_TICK,   40'd0, '0, 1'b0, '0));             // fires id 1
      queue_cmd(mk_cmd(ACT_QUERY,  40'd0, '0, 1'b0, '0));             // saturates
      queue_cmd(mk_cmd(ACT_ADD,    40'd5, 32'd0, 1'b1, '0));          // id 3, period 0
      queue_cmd(mk_cmd(ACT_TICK,   40'd5, '0, 1'b0, '0));
      queue_cmd(mk_cmd(ACT_TICK,   40'd6, '0, 1'b0, '0));
      queue_cmd(mk_cmd(ACT_CANCEL, 40'd6, '0, 1'b0, 32'd3));
      queue_cmd(mk_cmd(ACT_CANCEL, 40'd6, '0, 1'b0, 32'd3));          // already gone
      queue_cmd(mk_cmd(ACT_CANCEL, 40'd6, '0, 1'b0, 32'hFFFF_FFFF));
      queue_cmd(mk_cmd(ACT_SPARE_LO,          '1, '1, 1'b1, '1));
      queue_cmd(mk_cmd(ACT_SPARE_LO + 3'd1,   '1, '1, 1'b1, '1));
      queue_cmd(mk_cmd(ACT_SPARE_HI,          '1, '1, 1'b1, '1));
      queue_cmd(mk_cmd(ACT_ADD,    '1, 32'hFFFF_FFFF, 1'b1, '0));     // id 4, 41-bit deadline
      queue_cmd(mk_cmd(ACT_TICK,   '1, '0, 1'b0, '0));                // id 2 fires, reloads
      queue_cmd(mk_cmd(ACT_QUERY,  '1, '0, 1'b0, '0));
      queue_cmd(mk_cmd(ACT_CLEAR,  '1, '0, 1'b0, '0));
      queue_cmd(mk_cmd(ACT_ADD,    40'd100, 32'd1000, 1'b0, '0));     // id 5
      queue_cmd(mk_cmd(ACT_QUERY,  40'd400, '0, 1'b0, '0));           // 700 left
      queue_cmd(mk_cmd(ACT_QUERY,  40'd5000, '0, 1'b0, '0));          // overdue
      queue_cmd(mk_cmd(ACT_TICK,   40'd1100, '0, 1'b0, '0));

      // random: mostly plausible traffic on a moving time base, with
      // bursts that fill the table and some pure noise
      now_base = 40'd2000;
      id_hint  = 32'd6;
      n_rand   = 0;
      while (n_rand < RAND_CMDS) begin
         pick = $urandom_range(99);
         c    = noise_cmd();
         if (pick < 3) begin
            sel = $urandom_range(4);
            if (sel == 0)      now_base = {8'($urandom()), $urandom()};
            else if (sel == 1) now_base = 40'hFF_FFFF_FFFF - 40'($urandom_range(300));
            else               now_base = now_base + 40'($urandom_range(1 << 20));
         end else if (pick < 8) begin
            // fill (or overfill) the table with near-due timers, then tick
            burst = $urandom_range(18, 12);
            for (int k = 0; k < burst; k++) begin
               c          = noise_cmd();
               c.action   = ACT_ADD;
               c.now_ms   = now_base;
               c.delay_ms = $urandom_range(3);
               queue_cmd(c);
               id_hint++;
            end
            now_base = now_base + 40'd5;
            c        = noise_cmd();
            c.action = ACT_TICK;
            c.now_ms = now_base;
            queue_cmd(c);
            n_rand += burst + 1;
         end else begin
            c.now_ms = now_base;
            if (pick < 38) begin
               c.action = ACT_ADD;
               sel      = $urandom_range(99);
               if (sel < 75)      c.delay_ms = $urandom_range(40);
               else if (sel < 90) c.delay_ms = $urandom_range(5000);
               id_hint++;
            end else if (pick < 62) begin
               now_base = now_base + 40'($urandom_range(25));
               c.action = ACT_TICK;
               c.now_ms = now_base;
            end else if (pick < 72) begin
               c.action = ACT_QUERY;
            end else if (pick < 86) begin
               c.action = ACT_CANCEL;
               sel      = $urandom_range(9);
               if (sel < 7)       c.timer_id = id_hint - 32'($urandom_range(20));
               else if (sel == 7) c.timer_id = '0;
            end else if (pick < 89) begin
               c.action = ACT_CLEAR;
            end else if (pick < 92) begin
               c.action = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
            end else begin
               c = noise_cmd();
            end
            queue_cmd(c);
            if (c.action <= ACT_CLEAR) n_rand++;
         end
      end

      // each change of sender idling starts from a drained block
      stim_total = cmd_q.size();
      cmd_q[stim_total / 3].drain     = 1'b1;
      cmd_q[2 * stim_total / 3].drain = 1'b1;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (cmd_q.size() != 0 || start || sched_rsp_q.size() != 0);
      repeat (SLOTS + 4) @(negedge clock);   // catch stray results

      if (sched_rsp_q.size() != 0) begin
         $error("%0d predicted results never arrived", sched_rsp_q.size());
         n_mismatch++;
      end
      $display("Ran %0d commands and checked %0d results,", n_cmds_taken, n_rsp_seen);
      $display("including %0d timer fires and %0d adds refused on a full table.",
               n_fires, n_full_adds);
      if (n_mismatch == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/tts_pkg.sv
rtl/tts_ram.sv
rtl/tts_ctrl.sv
rtl/tts_dp.sv
rtl/timer_table_scheduler_core.sv
sim/tb_timer_table_scheduler_core.sv
